@@ rtl/sbq_pkg.sv @@
// Shared types and constants for the semaphore blocked-queue table.
// Used by the controller, the datapath and the top level.
`default_nettype none
package sbq_pkg;

    localparam int MAX_PROCS_DEF = 32;
    localparam int KEY_W         = 32;
    localparam int PID_W         = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_RMFIRST = 2'd1,
        KIND_RMNAMED = 2'd2,
        KIND_PEEK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BLOCKED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH,
        S_SWAIT,
        S_DEC,
        S_U1,
        S_U2,
        S_U3,
        S_U4,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SRCH,
        OP_APPEND,
        OP_CLAIM,
        OP_TGT_HEAD,
        OP_LD_LINKS,
        OP_UNLINK,
        OP_FIN
    } t_dp_op;

    typedef enum logic [1:0] {
        PO_ZERO,
        PO_HEAD,
        PO_TGT
    } t_pout_sel;

    typedef struct packed {
        t_dp_op    op;
        t_status   st;
        t_pout_sel po;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  key_zero;
        logic  p_oor;
        logic  bound_p;
        logic  hit;
        logic  last;
        logic  found;
        logic  free_ok;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/sbq_ctrl.sv @@
// Sequencer for the semaphore blocked-queue table.
// Depends on sbq_pkg; drives sbq_dpath through t_dp_cmd, reads t_dp_sts.
`default_nettype none
module sbq_ctrl
    import sbq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NOP;
        o_cmd.st = ST_OK;
        o_cmd.po = PO_ZERO;
        o_stall  = (r_state != S_IDLE);
        o_valid  = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_FIN;
                n_state  = S_OUT;
                case (i_sts.kind)
                    KIND_INSERT: begin
                        if (i_sts.key_zero || i_sts.p_oor) begin
                            o_cmd.st = ST_NOTFOUND;
                        end else if (i_sts.bound_p) begin
                            o_cmd.st = ST_BLOCKED;
                        end else begin
                            o_cmd.op = OP_NOP;
                            n_state  = S_SRCH;
                        end
                    end
                    KIND_RMNAMED: begin
                        if (i_sts.p_oor || !i_sts.bound_p) begin
                            o_cmd.st = ST_NOTFOUND;
                        end else begin
                            o_cmd.op = OP_NOP;
                            n_state  = S_U1;
                        end
                    end
                    default: begin
                        if (i_sts.key_zero) begin
                            o_cmd.st = ST_NOTFOUND;
                        end else begin
                            o_cmd.op = OP_NOP;
                            n_state  = S_SRCH;
                        end
                    end
                endcase
            end
            S_SRCH: begin
                o_cmd.op = OP_SRCH;
                if (i_sts.hit || i_sts.last) begin
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.op = OP_FIN;
                n_state  = S_OUT;
                case (i_sts.kind)
                    KIND_INSERT: begin
                        if (i_sts.found) begin
                            o_cmd.op = OP_APPEND;
                        end else if (i_sts.free_ok) begin
                            o_cmd.op = OP_CLAIM;
                        end else begin
                            o_cmd.st = ST_FULL;
                        end
                    end
                    KIND_RMFIRST: begin
                        if (i_sts.found) begin
                            o_cmd.op = OP_TGT_HEAD;
                            n_state  = S_U1;
                        end else begin
                            o_cmd.st = ST_NOTFOUND;
                        end
                    end
                    default: begin
                        if (i_sts.found) begin
                            o_cmd.po = PO_HEAD;
                        end else begin
                            o_cmd.st = ST_NOTFOUND;
                        end
                    end
                endcase
            end
            S_U1: begin
                n_state = S_U2;
            end
            S_U2: begin
                o_cmd.op = OP_LD_LINKS;
                n_state  = S_U3;
            end
            S_U3: begin
                n_state = S_U4;
            end
            S_U4: begin
                // unlink writes and the result land on the same edge
                o_cmd.op = OP_UNLINK;
                o_cmd.po = PO_TGT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/sbq_dpath.sv @@
// Datapath of the semaphore blocked-queue table: descriptor and process
// stores, key search and list updates. Depends on sbq_pkg.
`default_nettype none
module sbq_dpath
    import sbq_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [1:0]         i_kind,
    input  wire logic [KEY_W-1:0]   i_sem_key,
    input  wire logic [PID_W-1:0]   i_proc_id,
    output t_dp_sts                 o_sts,
    output logic [1:0]              o_status,
    output logic [PID_W-1:0]        o_proc_out
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);

    logic [KEY_W-1:0] m_key   [MAX_PROCS];
    logic [IW-1:0]    m_head  [MAX_PROCS];
    logic [IW-1:0]    m_tail  [MAX_PROCS];
    logic [IW-1:0]    m_next  [MAX_PROCS];
    logic [IW-1:0]    m_prev  [MAX_PROCS];
    logic [IW-1:0]    m_pdesc [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_dvalid;
    logic [MAX_PROCS-1:0] r_bound;

    t_kind            r_kind;
    logic [KEY_W-1:0] r_key;
    logic [PID_W-1:0] r_pid;
    logic [IW-1:0]    r_tgt, r_d, r_f, r_nx, r_pv, r_sidx, r_cidx;
    logic             r_cvld, r_found, r_free_ok;
    logic [KEY_W-1:0] q_key;
    logic [IW-1:0]    q_head, q_tail, q_next, q_prev, q_pdesc;
    logic [1:0]       r_status;
    logic [PID_W-1:0] r_pout;
    logic [IW-1:0]    w_p;
    logic             w_hit, w_is_head, w_is_tail;

    assign w_p       = IW'(r_pid);
    assign w_hit     = r_cvld && r_dvalid[r_cidx] && (q_key == r_key);
    assign w_is_head = (q_head == r_tgt);
    assign w_is_tail = (q_tail == r_tgt);

    assign o_sts.kind     = r_kind;
    assign o_sts.key_zero = (r_key == '0);
    assign o_sts.p_oor    = (int'(r_pid) >= MAX_PROCS);
    assign o_sts.bound_p  = r_bound[w_p];
    assign o_sts.hit      = w_hit;
    assign o_sts.last     = r_cvld && (r_cidx == LAST_IDX);
    assign o_sts.found    = r_found;
    assign o_sts.free_ok  = r_free_ok;
    assign o_status       = r_status;
    assign o_proc_out     = r_pout;

    // registered reads
    always_ff @(posedge i_clk) begin
        q_key   <= m_key[r_sidx];
        q_head  <= m_head[r_d];
        q_tail  <= m_tail[r_d];
        q_next  <= m_next[r_tgt];
        q_prev  <= m_prev[r_tgt];
        q_pdesc <= m_pdesc[r_tgt];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind  <= t_kind'(i_kind);
                r_key   <= i_sem_key;
                r_pid   <= i_proc_id;
                r_tgt   <= IW'(i_proc_id);
                r_sidx  <= '0;
            end
            OP_SRCH: begin
                if (r_sidx != LAST_IDX) begin
                    r_sidx <= r_sidx + 1'b1;
                end
                r_cidx <= r_sidx;
                if (w_hit) begin
                    r_d <= r_cidx;
                end
                if (r_cvld && !r_dvalid[r_cidx] && !r_free_ok) begin
                    r_f <= r_cidx;
                end
            end
            OP_TGT_HEAD: begin
                r_tgt <= q_head;
            end
            OP_LD_LINKS: begin
                r_d  <= q_pdesc;
                r_nx <= q_next;
                r_pv <= q_prev;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld    <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.op == OP_LOAD) begin
            r_cvld    <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.op == OP_SRCH) begin
            r_cvld <= 1'b1;
            if (w_hit) begin
                r_found <= 1'b1;
            end
            if (r_cvld && !r_dvalid[r_cidx]) begin
                r_free_ok <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN || i_cmd.op == OP_APPEND || i_cmd.op == OP_CLAIM ||
            i_cmd.op == OP_UNLINK) begin
            r_status <= i_cmd.st;
            case (i_cmd.po)
                PO_HEAD: r_pout <= PID_W'(q_head);
                PO_TGT:  r_pout <= PID_W'(r_tgt);
                default: r_pout <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLAIM) begin
            m_key[r_f] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLAIM) begin
            m_head[r_f] <= w_p;
        end else if (i_cmd.op == OP_UNLINK && w_is_head && !w_is_tail) begin
            m_head[r_d] <= r_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLAIM) begin
            m_tail[r_f] <= w_p;
        end else if (i_cmd.op == OP_APPEND) begin
            m_tail[r_d] <= w_p;
        end else if (i_cmd.op == OP_UNLINK && w_is_tail && !w_is_head) begin
            m_tail[r_d] <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_APPEND) begin
            m_next[q_tail] <= w_p;
        end else if (i_cmd.op == OP_UNLINK && !w_is_head && !w_is_tail) begin
            m_next[r_pv] <= r_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_APPEND) begin
            m_prev[w_p] <= q_tail;
        end else if (i_cmd.op == OP_UNLINK && !w_is_head && !w_is_tail) begin
            m_prev[r_nx] <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_APPEND) begin
            m_pdesc[w_p] <= r_d;
        end else if (i_cmd.op == OP_CLAIM) begin
            m_pdesc[w_p] <= r_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
            r_bound  <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLAIM: begin
                    r_dvalid[r_f] <= 1'b1;
                    r_bound[w_p]  <= 1'b1;
                end
                OP_APPEND: begin
                    r_bound[w_p] <= 1'b1;
                end
                OP_UNLINK: begin
                    // drop the descriptor when its last process leaves
                    if (w_is_head && w_is_tail) begin
                        r_dvalid[r_d] <= 1'b0;
                    end
                    r_bound[r_tgt] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/semaphore_blocked_queue_table_core.sv @@
// Semaphore blocked-queue table: a pool of keyed descriptors, each holding
// a FIFO of blocked processes. Usage notes:
//   Request channel: i_valid / o_stall with i_kind, i_sem_key, i_proc_id.
//   Result channel:  o_valid / i_stall with o_status, o_proc_out.
//   One request is worked at a time; o_stall stays high from acceptance
//   until its result has been taken.
//   Steps: requests settled without a key lookup go from the check state
//   straight to the result; insert and peek run a key search (it reads one
//   descriptor key per cycle from the key memory, registered behind the
//   address, and stops at a match or at the last descriptor); remove first
//   adds link reads after the search; remove named skips the search and
//   goes straight to the link reads.
//   The result is held in a register with o_valid high until i_stall is
//   low; the payload does not change while stalled.
//   Reset (i_rst_n low, synchronous) frees all descriptors and unbinds all
//   processes at once through valid bits; no clearing pass is needed.
// Depends on sbq_pkg, sbq_ctrl and sbq_dpath.
`default_nettype none
module semaphore_blocked_queue_table_core
    import sbq_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [1:0]       i_kind,
    input  wire logic [KEY_W-1:0] i_sem_key,
    input  wire logic [PID_W-1:0] i_proc_id,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_status,
    output logic [PID_W-1:0]      o_proc_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sbq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sbq_dpath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_kind     (i_kind),
        .i_sem_key  (i_sem_key),
        .i_proc_id  (i_proc_id),
        .o_sts      (w_sts),
        .o_status   (o_status),
        .o_proc_out (o_proc_out)
    );

endmodule
`default_nettype wire
